FILE: design/kiqs_pkg.sv
package kiqs_pkg;

   localparam int QUEUE_DEPTH = 512;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_RAW   = 2'd1;
   localparam logic [1:0] KIND_ASCII = 2'd2;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ST_FULL        = 2'd2;

   localparam logic [1:0] REG_ENTER_CODE   = 2'd0;
   localparam logic [1:0] REG_SHIFT_CODE   = 2'd1;
   localparam logic [1:0] REG_DEFAULT_HOLD = 2'd2;
   localparam logic [1:0] REG_GAP_TICKS    = 2'd3;

   localparam logic [6:0] CHAR_LF = 7'd10;
   localparam logic [6:0] CHAR_CR = 7'd13;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] key_code;
      logic       shift;
      logic [7:0] hold_ticks;
      logic [6:0] ascii_char;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] event_key;
      logic [1:0] status;
      logic       busy_res;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] enter_code;
      logic [7:0] shift_code;
      logic [7:0] default_hold;
      logic [3:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic sel_second;
      logic rsp_valid;
   } cmd_type;

   typedef struct packed {
      logic two_results;
   } stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_OUT0,
      S_OUT1
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] key;
      logic       sh;
   } map_type;

   // ASCII to positional key code; shifted symbols share the key of their base.
   function automatic map_type map_char(input logic [6:0] ch);
      map_type m;
      m.valid = 1'b1;
      m.sh    = 1'b1;
      m.key   = {1'b0, ch};
      if (ch >= 7'h41 && ch <= 7'h5A) begin
         m.sh = 1'b0;
      end else if (ch >= 7'h61 && ch <= 7'h7A) begin
         m.key = {1'b0, ch - 7'h20};
      end else if (ch >= 7'h30 && ch <= 7'h39) begin
         m.sh = 1'b0;
      end else begin
         unique case (ch)
            7'h20, 7'h2E, 7'h2C, 7'h2F, 7'h3B, 7'h2D, 7'h5B, 7'h5D, 7'h5C: m.sh = 1'b0;
            7'h3A: begin m.key = 8'h27; m.sh = 1'b0; end   // ':'
            7'h40: begin m.key = 8'h60; m.sh = 1'b0; end   // '@'
            7'h5E: begin m.key = 8'h3D; m.sh = 1'b0; end   // '^'
            7'h21: m.key = 8'h31;
            7'h22: m.key = 8'h32;
            7'h23: m.key = 8'h33;
            7'h24: m.key = 8'h34;
            7'h25: m.key = 8'h35;
            7'h26: m.key = 8'h36;
            7'h27: m.key = 8'h37;
            7'h28: m.key = 8'h38;
            7'h29: m.key = 8'h39;
            7'h2A: m.key = 8'h27;
            7'h2B: m.key = 8'h3B;
            7'h3D: m.key = 8'h2D;
            7'h3C: m.key = 8'h2C;
            7'h3E: m.key = 8'h2E;
            7'h3F: m.key = 8'h2F;
            default: begin
               m.valid = 1'b0;
               m.sh    = 1'b0;
               m.key   = 8'h00;
            end
         endcase
      end
      return m;
   endfunction

endpackage

FILE: design/kiqs_csr.sv
module kiqs_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output kiqs_pkg::cfg_type    cfg
);

   kiqs_pkg::cfg_type cfg_ff;
   kiqs_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            kiqs_pkg::REG_ENTER_CODE:   cfg_in.enter_code   = pwdata[7:0];
            kiqs_pkg::REG_SHIFT_CODE:   cfg_in.shift_code   = pwdata[7:0];
            kiqs_pkg::REG_DEFAULT_HOLD: cfg_in.default_hold = pwdata[7:0];
            kiqs_pkg::REG_GAP_TICKS:    cfg_in.gap_ticks    = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         kiqs_pkg::REG_ENTER_CODE:   prdata = {24'd0, cfg_ff.enter_code};
         kiqs_pkg::REG_SHIFT_CODE:   prdata = {24'd0, cfg_ff.shift_code};
         kiqs_pkg::REG_DEFAULT_HOLD: prdata = {24'd0, cfg_ff.default_hold};
         kiqs_pkg::REG_GAP_TICKS:    prdata = {28'd0, cfg_ff.gap_ticks};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_code   <= 8'd13;
         cfg_ff.shift_code   <= 8'd200;
         cfg_ff.default_hold <= 8'd3;
         cfg_ff.gap_ticks    <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/kiqs_ctrl.sv
module kiqs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  kiqs_pkg::stat_type   stat,
   output kiqs_pkg::cmd_type    cmd
);

   kiqs_pkg::state_type state_ff;
   kiqs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kiqs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         kiqs_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) state_in = kiqs_pkg::S_EXEC;
         end
         kiqs_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = kiqs_pkg::S_OUT0;
         end
         kiqs_pkg::S_OUT0: begin
            cmd.rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = stat.two_results ? kiqs_pkg::S_OUT1 : kiqs_pkg::S_IDLE;
            end
         end
         kiqs_pkg::S_OUT1: begin
            cmd.rsp_valid  = 1'b1;
            cmd.sel_second = 1'b1;
            if (rsp_ready) state_in = kiqs_pkg::S_IDLE;
         end
         default: state_in = kiqs_pkg::S_IDLE;
      endcase
   end

endmodule

FILE: design/kiqs_dp.sv
module kiqs_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  kiqs_pkg::req_type    req_data,
   input  kiqs_pkg::cfg_type    cfg,
   input  kiqs_pkg::cmd_type    cmd,
   output kiqs_pkg::stat_type   stat,
   output kiqs_pkg::rsp_type    rsp_data
);

   typedef struct packed {
      logic [7:0] hold;
      logic       sh;
      logic [7:0] key;
   } entry_type;

   entry_type                    mem [kiqs_pkg::QUEUE_DEPTH];
   entry_type                    rd_entry_ff;

   kiqs_pkg::req_type            item_ff;
   logic [kiqs_pkg::PTR_W-1:0]   rp_ff, rp_in, wp_ff, wp_in, wp_next, rp_next;
   logic [8:0]                   phase_ff, phase_in;
   logic [7:0]                   cur_key_ff, cur_key_in;
   logic                         cur_shift_ff, cur_shift_in;

   // two results per item at most, held until delivered
   logic [1:0]                   ev0_kind_ff, ev0_kind_in, ev1_kind_ff, ev1_kind_in;
   logic [7:0]                   ev0_key_ff, ev0_key_in, ev1_key_ff, ev1_key_in;
   logic [1:0]                   status_ff, status_in;
   logic                         busy_ff, busy_in, two_ff, two_in;

   kiqs_pkg::map_type            mapped;
   logic [7:0]                   eff_hold, cnt_dec;
   logic                         full, do_push, holding, in_gap, is_crlf;
   entry_type                    push_entry;

   assign eff_hold = (cfg.default_hold == 8'd0) ? 8'd1 : cfg.default_hold;
   assign wp_next  = (wp_ff == kiqs_pkg::PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_next  = (rp_ff == kiqs_pkg::PTR_LAST) ? '0 : rp_ff + 1'b1;
   assign full     = (wp_next == rp_ff);
   assign mapped   = kiqs_pkg::map_char(item_ff.ascii_char);
   assign is_crlf  = (item_ff.ascii_char == kiqs_pkg::CHAR_LF) ||
                     (item_ff.ascii_char == kiqs_pkg::CHAR_CR);
   assign holding  = (phase_ff != 9'd0) && !phase_ff[8];
   assign in_gap   = phase_ff[8];
   assign cnt_dec  = phase_ff[7:0] - 8'd1;

   always_comb begin
      push_entry   = '0;
      do_push      = 1'b0;
      status_in    = kiqs_pkg::ST_OK;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      phase_in     = phase_ff;
      cur_key_in   = cur_key_ff;
      cur_shift_in = cur_shift_ff;
      ev0_kind_in  = kiqs_pkg::EV_NONE;
      ev0_key_in   = 8'd0;
      ev1_kind_in  = kiqs_pkg::EV_NONE;
      ev1_key_in   = 8'd0;
      two_in       = 1'b0;

      unique case (item_ff.kind)
         kiqs_pkg::KIND_RAW: begin
            push_entry.key  = item_ff.key_code;
            push_entry.sh   = item_ff.shift;
            push_entry.hold = (item_ff.hold_ticks == 8'd0) ? eff_hold : item_ff.hold_ticks;
            do_push         = 1'b1;
         end
         kiqs_pkg::KIND_ASCII: begin
            push_entry.hold = eff_hold;
            if (is_crlf) begin
               push_entry.key = cfg.enter_code;
               do_push        = 1'b1;
            end else if (mapped.valid) begin
               push_entry.key = mapped.key;
               push_entry.sh  = mapped.sh;
               do_push        = 1'b1;
            end else begin
               status_in = kiqs_pkg::ST_UNSUPPORTED;
            end
         end
         kiqs_pkg::KIND_TICK: begin
            priority if (holding) begin
               phase_in = {1'b0, cnt_dec};
               if (cnt_dec == 8'd0) begin
                  ev0_kind_in = kiqs_pkg::EV_RELEASE;
                  ev0_key_in  = cur_key_ff;
                  if (cur_shift_ff) begin
                     ev1_kind_in = kiqs_pkg::EV_RELEASE;
                     ev1_key_in  = cfg.shift_code;
                     two_in      = 1'b1;
                  end
                  phase_in = (cfg.gap_ticks != 4'd0) ? {5'b10000, cfg.gap_ticks} : 9'd0;
               end
            end else if (in_gap) begin
               phase_in = (phase_ff[7:0] > 8'd1) ? {1'b1, cnt_dec} : 9'd0;
            end else if (rp_ff != wp_ff) begin
               rp_in        = rp_next;
               cur_key_in   = rd_entry_ff.key;
               cur_shift_in = rd_entry_ff.sh;
               phase_in     = {1'b0, rd_entry_ff.hold};
               if (rd_entry_ff.sh) begin
                  ev0_kind_in = kiqs_pkg::EV_PRESS;
                  ev0_key_in  = cfg.shift_code;
                  ev1_kind_in = kiqs_pkg::EV_PRESS;
                  ev1_key_in  = rd_entry_ff.key;
                  two_in      = 1'b1;
               end else begin
                  ev0_kind_in = kiqs_pkg::EV_PRESS;
                  ev0_key_in  = rd_entry_ff.key;
               end
            end else begin
               // idle with an empty queue: the tick only reports status
            end
         end
         default: ;
      endcase

      if (do_push) begin
         if (full) begin
            status_in = kiqs_pkg::ST_FULL;
            do_push   = 1'b0;
         end else begin
            wp_in = wp_next;
         end
      end

      busy_in = (rp_in != wp_in) || (phase_in != 9'd0);
   end

   // read data is sampled from the read pointer every cycle; the pointer is
   // stable between acceptance and execution
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rp_ff];
      if (cmd.exec && do_push) begin
         mem[wp_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         phase_ff     <= 9'd0;
         cur_key_ff   <= 8'd0;
         cur_shift_ff <= 1'b0;
         two_ff       <= 1'b0;
      end else if (cmd.exec) begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         phase_ff     <= phase_in;
         cur_key_ff   <= cur_key_in;
         cur_shift_ff <= cur_shift_in;
         two_ff       <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.exec) begin
         ev0_kind_ff <= ev0_kind_in;
         ev0_key_ff  <= ev0_key_in;
         ev1_kind_ff <= ev1_kind_in;
         ev1_key_ff  <= ev1_key_in;
         status_ff   <= status_in;
         busy_ff     <= busy_in;
      end
   end

   assign stat.two_results = two_ff;

   always_comb begin
      rsp_data.event_kind = cmd.sel_second ? ev1_kind_ff : ev0_kind_ff;
      rsp_data.event_key  = cmd.sel_second ? ev1_key_ff : ev0_key_ff;
      rsp_data.status     = status_ff;
      rsp_data.busy_res   = busy_ff;
      rsp_data.last       = cmd.sel_second | ~two_ff;
   end

endmodule

FILE: design/key_injection_queue_sequencer.sv
// Channel  Ports                                  Direction
// req      req_valid / req_ready / req_data       in   one tick or enqueue transaction
// rsp      rsp_valid / rsp_ready / rsp_data       out  one or two results per request
// csr      psel penable pwrite paddr pwdata ...   in   APB register access
//
// One request at a time: accept, execute (queue RAM read data is registered),
// then one or two responses.
// The queue is a 512 x 17 single-write RAM; entries are never cleared, reset
// only zeroes the pointers, sequencer phase, current key and shift, two-result flag.
// A stalled response holds the controller; no new request is taken until
// the last response of the current one is accepted.
module key_injection_queue_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kiqs_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kiqs_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   kiqs_pkg::cfg_type  cfg;
   kiqs_pkg::cmd_type  cmd;
   kiqs_pkg::stat_type stat;

   kiqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kiqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kiqs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = cmd.rsp_valid;

endmodule
